[hdl/assert_macros.svh]
// assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("lbl failed");
`define AST_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("lbl failed");
`else
`define AST_HOLD(lbl, clk, rst, prop)
`define AST_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/ist_pkg.sv]
`default_nettype none
package ist_pkg;
   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic tail;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;
endpackage
`default_nettype wire

[hdl/interval_set_table.sv]
// channel | dir | tdata (low bit up)                      | tuser
// req     | in  | left[31:0], right[31:0]                  | action[1:0]
// rsp     | out | covered, status[1:0], interval_count, 0s | -
// One item at a time. The scan visits each stored interval in turn, with an
// extra step for a remove that splits an entry or an add that places before a
// neighbour; then come tail, commit and accept. Reset (synchronous) empties
// the table; no clearing pass.
// A held result blocks only the commit step; the next item is taken meanwhile.
`default_nettype none
module interval_set_table #(
   parameter int MAX_INTERVALS = 16,
   parameter int COORD_BITS    = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic [63:0] req_tdata,  // left[31:0], right[63:32]
   input  wire logic [1:0]  req_tuser,  // action
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [((3 + $clog2(MAX_INTERVALS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
   // covered[0], status[2:1], interval_count, zero fill
);
   import ist_pkg::*;

   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int OW = ((3 + CW + 7) / 8) * 8;

   cmd_type       cmd;
   stat_type      stat;
   logic          covered;
   logic [1:0]    status;
   logic [CW-1:0] interval_count;

   ist_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   ist_dpath #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS), .CW(CW)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .action(req_tuser), .left(req_tdata[31:0]), .right(req_tdata[63:32]),
      .covered(covered), .status(status), .interval_count(interval_count)
   );

   assign rsp_tdata = OW'({interval_count, status, covered});
endmodule
`default_nettype wire

[hdl/ist_ctrl.sv]
`default_nettype none
module ist_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output ist_pkg::cmd_type      cmd,
   input  wire ist_pkg::stat_type stat
);
   import ist_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SCAN;
         S_SCAN:   if (stat.scan_done) state_in = S_TAIL;
         S_TAIL:   state_in = S_COMMIT;
         S_COMMIT: if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         S_SCAN:   cmd.step   = !stat.scan_done;
         S_TAIL:   cmd.tail   = 1'b1;
         S_COMMIT: cmd.commit = slot_free;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   `include "assert_macros.svh"
   `AST_IMPL(a_rsp_from_commit, clock, reset, $rose(valid_ff), $past(state_ff == S_COMMIT))
   `AST_IMPL(a_one_step, clock, reset, cmd.step, state_ff == S_SCAN && !cmd.commit)
   `AST_IMPL(a_tail_then_commit, clock, reset, state_ff == S_TAIL, ##1 state_ff == S_COMMIT)
endmodule
`default_nettype wire

[hdl/ist_dpath.sv]
`default_nettype none
module ist_dpath #(
   parameter int MAX_INTERVALS = 16,
   parameter int COORD_BITS    = 32,
   parameter int CW            = $clog2(MAX_INTERVALS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ist_pkg::cmd_type  cmd,
   output ist_pkg::stat_type      stat,
   input  wire logic [1:0]        action,
   input  wire logic [31:0]       left,
   input  wire logic [31:0]       right,
   output logic                   covered,
   output logic [1:0]             status,
   output logic [CW-1:0]          interval_count
);
   import ist_pkg::*;

   localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int NW = $clog2(MAX_INTERVALS + 2);
   localparam logic [NW-1:0] N_MAX  = NW'(MAX_INTERVALS);
   localparam logic [NW-1:0] N_OVER = NW'(MAX_INTERVALS + 1);

   // two banks: live one is read, the other collects the new table
   logic [COORD_BITS-1:0] st_mem [2][MAX_INTERVALS];
   logic [COORD_BITS-1:0] en_mem [2][MAX_INTERVALS];

   logic                  bank_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         i_ff, i_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [COORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   action_type            act_ff;
   logic                  skip_ff, placed_ff, placed_in, ph_ff, ph_in, cov_ff, cov_in;
   logic                  cov_out_ff;
   status_type            status_ff;
   logic [CW-1:0]         cnt_out_ff;

   logic [COORD_BITS-1:0] s, e, lo_c, hi_c, wr_s, wr_e;
   logic                  wr, full, upd;

   assign lo_c = COORD_BITS'(left);
   assign hi_c = COORD_BITS'(right);
   assign s = st_mem[bank_ff][i_ff[IW-1:0]];
   assign e = en_mem[bank_ff][i_ff[IW-1:0]];
   assign stat.scan_done = skip_ff || (i_ff == count_ff);

   always_comb begin
      i_in      = i_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      placed_in = placed_ff;
      ph_in     = ph_ff;
      cov_in    = cov_ff;
      wr        = 1'b0;
      wr_s      = s;
      wr_e      = e;
      if (cmd.step) begin
         case (act_ff)
            ACT_ADD: begin
               if (e < lo_ff) begin
                  wr   = 1'b1;
                  i_in = i_ff + 1'b1;
               end else if (s > hi_ff) begin
                  wr = 1'b1;
                  if (!placed_ff) begin
                     wr_s      = lo_ff;
                     wr_e      = hi_ff;
                     placed_in = 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  if (s < lo_ff) lo_in = s;
                  if (e > hi_ff) hi_in = e;
                  i_in = i_ff + 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (e <= lo_ff || s >= hi_ff) begin
                  wr   = 1'b1;
                  i_in = i_ff + 1'b1;
               end else if (!ph_ff && s < lo_ff) begin
                  wr   = 1'b1;
                  wr_e = lo_ff;
                  if (e > hi_ff) ph_in = 1'b1;
                  else i_in = i_ff + 1'b1;
               end else begin
                  wr    = e > hi_ff;
                  wr_s  = hi_ff;
                  ph_in = 1'b0;
                  i_in  = i_ff + 1'b1;
               end
            end
            ACT_QUERY: begin
               if (s <= lo_ff && e >= hi_ff) cov_in = 1'b1;
               i_in = i_ff + 1'b1;
            end
            default: i_in = count_ff;
         endcase
      end else if (cmd.tail && act_ff == ACT_ADD && !placed_ff && !skip_ff) begin
         wr   = 1'b1;
         wr_s = lo_ff;
         wr_e = hi_ff;
      end
      n_in = n_ff;
      if (wr && n_ff != N_OVER) n_in = n_ff + 1'b1;
   end

   assign full = n_ff > N_MAX;
   assign upd  = !skip_ff && (act_ff == ACT_ADD || act_ff == ACT_REMOVE);

   always_ff @(posedge clock) begin
      if (wr && n_ff < N_MAX) begin
         st_mem[!bank_ff][n_ff[IW-1:0]] <= wr_s;
         en_mem[!bank_ff][n_ff[IW-1:0]] <= wr_e;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff    <= action_type'(action);
         lo_ff     <= lo_c;
         hi_ff     <= hi_c;
         skip_ff   <= (lo_c >= hi_c) || action == ACT_NONE;
         i_ff      <= '0;
         n_ff      <= '0;
         placed_ff <= 1'b0;
         ph_ff     <= 1'b0;
         cov_ff    <= 1'b0;
      end else begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         i_ff      <= i_in;
         n_ff      <= n_in;
         placed_ff <= placed_in;
         ph_ff     <= ph_in;
         cov_ff    <= cov_in;
      end
      if (cmd.commit) begin
         cov_out_ff <= cov_ff && !skip_ff;
         if (lo_ff >= hi_ff) status_ff <= ST_EMPTY;
         else if (upd && full) status_ff <= ST_FULL;
         else status_ff <= ST_DONE;
         cnt_out_ff <= (upd && !full) ? CW'(n_ff) : count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
      end else if (cmd.commit && upd && !full) begin
         bank_ff  <= !bank_ff;
         count_ff <= CW'(n_ff);
      end
   end

   assign covered        = cov_out_ff;
   assign status         = status_ff;
   assign interval_count = cnt_out_ff;

   `include "assert_macros.svh"
   `AST_HOLD(a_count_range, clock, reset, count_ff <= CW'(MAX_INTERVALS))
   `AST_IMPL(a_scan_in_table, clock, reset, cmd.step, i_ff < count_ff)
   `AST_IMPL(a_split_pending, clock, reset, ph_ff, act_ff == ACT_REMOVE)
endmodule
`default_nettype wire
